### rtl/hlvsf_pkg.sv
// ----------------------------------------------------------------------------
// hlvsf_pkg
// Shared widths, register indexes, the per-item side record and the helper
// functions of the variable-stiffness hopping leg force block.
// ----------------------------------------------------------------------------
package hlvsf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned Q_W   = 48;   // quotient bits produced by the divider
  localparam int unsigned DEN_W = 67;   // |a| (34 bits) times |b| (33 bits)
  localparam int unsigned NUM_W = 96;   // mass (31 bits) times |numerator| (65 bits)
  localparam int unsigned G2_W  = 30;   // 2g, signed, wide enough up to 24 fraction bits
  localparam int unsigned MAG_W = 81;   // widest magnitude handed to the saturator

  localparam longint unsigned GRAV_Q32 = 64'd42119241033;

  localparam logic [1:0] REG_BODY_MASS      = 2'd0;
  localparam logic [1:0] REG_NATURAL_LENGTH = 2'd1;
  localparam logic [1:0] REG_APEX_HEIGHT    = 2'd2;
  localparam logic [1:0] REG_BOTTOM_HEIGHT  = 2'd3;

  // Data that travels alongside the division.
  typedef struct packed {
    logic               neg;      // stiffness is negative
    logic               zero;     // divisor is zero
    logic               comp;     // compression formula in use
    logic               flight;   // body above the natural length
    logic               big;      // quotient does not fit Q_W bits
    logic signed [32:0] defl;     // height minus natural length
  } side_t;

  // Twice gravity, rounded half up to f fraction bits.
  function automatic logic signed [G2_W-1:0] grav2(int unsigned f);
    logic [63:0] g;
    g = (GRAV_Q32 + (64'd1 << (31 - f))) >> (32 - f);
    return G2_W'(g << 1);
  endfunction

  // Magnitude clipped to the signed 48-bit range of the given sign.
  function automatic logic [Q_W-1:0] sat_mag(logic [MAG_W-1:0] m, logic neg);
    logic [MAG_W-1:0] lim;
    lim = neg ? (MAG_W'(1) << (Q_W - 1)) : ((MAG_W'(1) << (Q_W - 1)) - MAG_W'(1));
    return (m > lim) ? Q_W'(lim) : Q_W'(m);
  endfunction

endpackage

### rtl/hlvsf_div.sv
// ----------------------------------------------------------------------------
// hlvsf_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module hlvsf_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [hlvsf_pkg::Q_W-1:0]     num_lo_i,
  input  logic [hlvsf_pkg::DEN_W-1:0]   rem_i,
  input  logic [hlvsf_pkg::DEN_W-1:0]   den_i,
  input  hlvsf_pkg::side_t              side_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hlvsf_pkg::Q_W-1:0]     quot_o,
  output hlvsf_pkg::side_t              side_o
);

  localparam int unsigned QW = hlvsf_pkg::Q_W;
  localparam int unsigned DW = hlvsf_pkg::DEN_W;

  logic [QW-1:0]            v_q;
  logic [DW-1:0]            rem_q  [QW];
  logic [DW-1:0]            rem_d  [QW];
  logic [QW-1:0]            nb_q   [QW];
  logic [QW-1:0]            nb_d   [QW];
  logic [QW-1:0]            quot_q [QW];
  logic [QW-1:0]            quot_d [QW];
  logic [DW-1:0]            den_q  [QW];
  logic [DW-1:0]            den_d  [QW];
  hlvsf_pkg::side_t         side_q [QW];
  hlvsf_pkg::side_t         side_d [QW];
  logic [QW-1:0]            v_d;
  logic                     en;

  // The whole column advances together whenever the last stage can move on.
  assign en         = ~v_q[QW-1] | out_ready_i;
  assign in_ready_o = en;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] src_rem;
    logic [QW-1:0] src_nb;
    logic [QW-1:0] src_quot;
    logic [DW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign src_rem   = rem_i;
      assign src_nb    = num_lo_i;
      assign src_quot  = '0;
      assign den_d[i]  = den_i;
      assign side_d[i] = side_i;
      assign v_d[i]    = in_valid_i;
    end else begin : g_next
      assign src_rem   = rem_q[i-1];
      assign src_nb    = nb_q[i-1];
      assign src_quot  = quot_q[i-1];
      assign den_d[i]  = den_q[i-1];
      assign side_d[i] = side_q[i-1];
      assign v_d[i]    = v_q[i-1];
    end

    assign trial     = {src_rem, src_nb[QW-1]};
    assign ge        = trial >= {1'b0, den_d[i]};
    assign rem_d[i]  = ge ? DW'(trial - {1'b0, den_d[i]}) : trial[DW-1:0];
    assign nb_d[i]   = {src_nb[QW-2:0], 1'b0};
    assign quot_d[i] = {src_quot[QW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_d[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[i]  <= rem_d[i];
        nb_q[i]   <= nb_d[i];
        quot_q[i] <= quot_d[i];
        den_q[i]  <= den_d[i];
        side_q[i] <= side_d[i];
      end
    end
  end

  assign out_valid_o = v_q[QW-1];
  assign quot_o      = quot_q[QW-1];
  assign side_o      = side_q[QW-1];

  // When the quotient fits, the final remainder is always below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[QW-1] && !side_q[QW-1].zero && !side_q[QW-1].big |->
      rem_q[QW-1] < den_q[QW-1])
    else $error("divider remainder not below divisor");

endmodule

### rtl/hopping_leg_variable_stiffness_force_top.sv
// ----------------------------------------------------------------------------
// hopping_leg_variable_stiffness_force_top
// Spring stiffness and leg force of a variable-stiffness hopping leg.
// ----------------------------------------------------------------------------
// Each input beat carries a body height and a vertical velocity in signed
// fixed point with FRAC_BITS fraction bits, and produces exactly one result
// beat: the stiffness that takes the body to the apex height (decompressing,
// velocity not negative) or to the bottom height (compressing), the leg
// force minus stiffness times deflection (zero in flight), and two flags.
// The block takes a new beat every cycle unless back-pressure from the
// output has filled the pipeline; each beat passes through the 48-stage
// divider, one quotient bit per stage. Six stages ahead of it form the
// differences, the products and the dividend, and three stages after it
// saturate the stiffness and form the force, the last of them being the
// output register. The stages before and after the divider close up
// bubbles, so input beats are still taken while a finished result waits.
// Configuration is written through a plain write port and must only be
// changed while no beat is in flight.
module hopping_leg_variable_stiffness_force_top #(
  parameter int unsigned FRAC_BITS = hlvsf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] height_i,
  input  logic signed [31:0] velocity_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [47:0] stiffness_o,
  output logic signed [47:0] leg_force_o,
  output logic               compressing_o,
  output logic               divide_fault_o
);

  localparam int unsigned QW = hlvsf_pkg::Q_W;
  localparam int unsigned DW = hlvsf_pkg::DEN_W;
  localparam int unsigned NW = hlvsf_pkg::NUM_W;
  localparam int unsigned MW = hlvsf_pkg::MAG_W;
  localparam logic signed [hlvsf_pkg::G2_W-1:0] G2 = hlvsf_pkg::grav2(FRAC_BITS);

  // Configuration registers.
  logic [30:0]        mass_q;
  logic signed [31:0] z0_q, zd_q, zb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= 31'd65536;
      z0_q   <= 32'sd65536;
      zd_q   <= 32'sd98304;
      zb_q   <= 32'sd32768;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hlvsf_pkg::REG_BODY_MASS:      mass_q <= cfg_wdata_i[30:0];
        hlvsf_pkg::REG_NATURAL_LENGTH: z0_q   <= $signed(cfg_wdata_i);
        hlvsf_pkg::REG_APEX_HEIGHT:    zd_q   <= $signed(cfg_wdata_i);
        hlvsf_pkg::REG_BOTTOM_HEIGHT:  zb_q   <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: six stages. a_en[i] loads stage i when it is empty or when
  // its contents move on, so bubbles close up.
  // ---------------------------------------------------------------------------
  logic [5:0] a_v_q;
  logic [5:0] a_en;
  logic       div_in_ready;

  always_comb begin
    a_en[5] = ~a_v_q[5] | div_in_ready;
    for (int i = 4; i >= 0; i--) begin
      a_en[i] = ~a_v_q[i] | a_en[i+1];
    end
  end

  assign in_ready_o = a_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= '0;
    end else begin
      if (a_en[0]) a_v_q[0] <= in_valid_i;
      for (int i = 1; i < 6; i++) begin
        if (a_en[i]) a_v_q[i] <= a_v_q[i-1];
      end
    end
  end

  // Stage 1: differences and magnitudes.
  logic signed [32:0] dz, dzd, b_diff, defl;
  logic signed [34:0] a_diff;
  logic [32:0]        dz_mag, b_mag;
  logic [33:0]        a_mag;
  logic [31:0]        v_mag;

  assign dz     = 33'(z0_q) - 33'(height_i);
  assign dzd    = 33'(zd_q) - 33'(height_i);
  assign b_diff = 33'(height_i) - 33'(zb_q);
  assign defl   = 33'(height_i) - 33'(z0_q);
  assign a_diff = (35'(z0_q) <<< 1) - 35'(height_i) - 35'(zb_q);
  assign dz_mag = 33'(dz[32] ? -34'(dz) : 34'(dz));
  assign b_mag  = 33'(b_diff[32] ? -34'(b_diff) : 34'(b_diff));
  assign a_mag  = 34'(a_diff[34] ? -a_diff : a_diff);
  assign v_mag  = velocity_i[31] ? 32'(~velocity_i + 32'sd1) : 32'(velocity_i);

  logic               s1_comp_q, s1_flight_q, s1_dneg_q;
  logic signed [32:0] s1_gsel_q, s1_defl_q;
  logic [31:0]        s1_vmag_q;
  logic [33:0]        s1_ma_q;
  logic [32:0]        s1_mb_q;

  always_ff @(posedge clk_i) begin
    if (a_en[0]) begin
      s1_comp_q   <= velocity_i[31];
      s1_flight_q <= height_i > z0_q;
      s1_dneg_q   <= velocity_i[31] & (a_diff[34] ^ b_diff[32]);
      s1_gsel_q   <= velocity_i[31] ? b_diff : dzd;
      s1_defl_q   <= defl;
      s1_vmag_q   <= v_mag;
      s1_ma_q     <= velocity_i[31] ? a_mag : {1'b0, dz_mag};
      s1_mb_q     <= velocity_i[31] ? b_mag : dz_mag;
    end
  end

  // Stage 2: 2g times the height term, velocity squared and the divisor.
  logic               s2_comp_q, s2_flight_q, s2_dneg_q;
  logic signed [32:0] s2_defl_q;
  logic signed [62:0] s2_gp_q;
  logic [63:0]        s2_vsq_q;
  logic [DW-1:0]      s2_den_q;

  always_ff @(posedge clk_i) begin
    if (a_en[1]) begin
      s2_comp_q   <= s1_comp_q;
      s2_flight_q <= s1_flight_q;
      s2_dneg_q   <= s1_dneg_q;
      s2_defl_q   <= s1_defl_q;
      s2_gp_q     <= 63'(G2) * 63'(s1_gsel_q);
      s2_vsq_q    <= 64'(s1_vmag_q) * 64'(s1_vmag_q);
      s2_den_q    <= DW'(s1_ma_q) * DW'(s1_mb_q);
    end
  end

  // Stage 3: numerator, its sign and magnitude, and the zero-divisor test.
  logic signed [65:0] numer;
  logic [64:0]        numer_mag;

  assign numer = s2_comp_q ? 66'(s2_gp_q) + $signed({2'b00, s2_vsq_q})
                           : 66'(s2_gp_q) - $signed({2'b00, s2_vsq_q});
  assign numer_mag = 65'(numer[65] ? -numer : numer);

  logic               s3_comp_q, s3_flight_q, s3_neg_q, s3_zero_q;
  logic signed [32:0] s3_defl_q;
  logic [64:0]        s3_nmag_q;
  logic [DW-1:0]      s3_den_q;

  always_ff @(posedge clk_i) begin
    if (a_en[2]) begin
      s3_comp_q   <= s2_comp_q;
      s3_flight_q <= s2_flight_q;
      s3_neg_q    <= numer[65] ^ s2_dneg_q;
      s3_zero_q   <= s2_den_q == '0;
      s3_defl_q   <= s2_defl_q;
      s3_nmag_q   <= numer_mag;
      s3_den_q    <= s2_den_q;
    end
  end

  // Stage 4: mass times the numerator magnitude, in two partial products.
  logic               s4_comp_q, s4_flight_q, s4_neg_q, s4_zero_q;
  logic signed [32:0] s4_defl_q;
  logic [63:0]        s4_plo_q;
  logic [62:0]        s4_phi_q;
  logic [DW-1:0]      s4_den_q;

  always_ff @(posedge clk_i) begin
    if (a_en[3]) begin
      s4_comp_q   <= s3_comp_q;
      s4_flight_q <= s3_flight_q;
      s4_neg_q    <= s3_neg_q;
      s4_zero_q   <= s3_zero_q;
      s4_defl_q   <= s3_defl_q;
      s4_plo_q    <= 64'(mass_q) * 64'(s3_nmag_q[32:0]);
      s4_phi_q    <= 63'(mass_q) * 63'(s3_nmag_q[64:33]);
      s4_den_q    <= s3_den_q;
    end
  end

  // Stage 5: dividend.
  logic               s5_comp_q, s5_flight_q, s5_neg_q, s5_zero_q;
  logic signed [32:0] s5_defl_q;
  logic [NW-1:0]      s5_num_q;
  logic [DW-1:0]      s5_den_q;

  always_ff @(posedge clk_i) begin
    if (a_en[4]) begin
      s5_comp_q   <= s4_comp_q;
      s5_flight_q <= s4_flight_q;
      s5_neg_q    <= s4_neg_q;
      s5_zero_q   <= s4_zero_q;
      s5_defl_q   <= s4_defl_q;
      s5_num_q    <= NW'(s4_plo_q) + (NW'(s4_phi_q) << 33);
      s5_den_q    <= s4_den_q;
    end
  end

  // Stage 6: the quotient fits QW bits exactly when the top part of the
  // dividend is below the divisor; that top part is then the first remainder.
  hlvsf_pkg::side_t   s6_side_q;
  logic [QW-1:0]      s6_nlo_q;
  logic [DW-1:0]      s6_rem_q, s6_den_q;

  always_ff @(posedge clk_i) begin
    if (a_en[5]) begin
      s6_side_q.neg    <= s5_neg_q;
      s6_side_q.zero   <= s5_zero_q;
      s6_side_q.comp   <= s5_comp_q;
      s6_side_q.flight <= s5_flight_q;
      s6_side_q.big    <= DW'(s5_num_q[NW-1:QW]) >= s5_den_q;
      s6_side_q.defl   <= s5_defl_q;
      s6_nlo_q         <= s5_num_q[QW-1:0];
      s6_rem_q         <= DW'(s5_num_q[NW-1:QW]);
      s6_den_q         <= s5_den_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider.
  // ---------------------------------------------------------------------------
  logic             div_out_valid, div_out_ready;
  logic [QW-1:0]    div_quot;
  hlvsf_pkg::side_t div_side;

  hlvsf_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_v_q[5]),
    .in_ready_o  (div_in_ready),
    .num_lo_i    (s6_nlo_q),
    .rem_i       (s6_rem_q),
    .den_i       (s6_den_q),
    .side_i      (s6_side_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (div_out_ready),
    .quot_o      (div_quot),
    .side_o      (div_side)
  );

  // ---------------------------------------------------------------------------
  // Back end: three stages, the last being the output register.
  // ---------------------------------------------------------------------------
  logic [2:0] c_v_q;
  logic [2:0] c_en;

  assign c_en[2]       = ~c_v_q[2] | out_ready_i;
  assign c_en[1]       = ~c_v_q[1] | c_en[2];
  assign c_en[0]       = ~c_v_q[0] | c_en[1];
  assign div_out_ready = c_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= '0;
    end else begin
      if (c_en[0]) c_v_q[0] <= div_out_valid;
      if (c_en[1]) c_v_q[1] <= c_v_q[0];
      if (c_en[2]) c_v_q[2] <= c_v_q[1];
    end
  end

  // Stage C1: saturated stiffness and its magnitude; a zero divisor forces 0.
  logic [QW-1:0] k_mag;
  logic [MW-1:0] q_ext;

  assign q_ext = div_side.big ? {MW{1'b1}} : MW'(div_quot);
  assign k_mag = div_side.zero ? '0 : hlvsf_pkg::sat_mag(q_ext, div_side.neg);

  logic               c1_comp_q, c1_fault_q, c1_flight_q, c1_dneg_q;
  logic signed [47:0] c1_k_q;
  logic [QW-1:0]      c1_kmag_q;
  logic [32:0]        c1_dmag_q;

  always_ff @(posedge clk_i) begin
    if (c_en[0]) begin
      c1_comp_q   <= div_side.comp;
      c1_fault_q  <= div_side.comp & div_side.zero;
      c1_flight_q <= div_side.flight;
      c1_dneg_q   <= div_side.defl[32];
      c1_k_q      <= (div_side.neg && !div_side.zero) ? $signed(-k_mag) : $signed(k_mag);
      c1_kmag_q   <= k_mag;
      c1_dmag_q   <= 33'(div_side.defl[32] ? -34'(div_side.defl) : 34'(div_side.defl));
    end
  end

  // Stage C2: stiffness times deflection in two partial products. The force
  // is negative when stiffness and deflection share a sign.
  logic               c2_comp_q, c2_fault_q, c2_flight_q, c2_fneg_q;
  logic signed [47:0] c2_k_q;
  logic [56:0]        c2_plo_q, c2_phi_q;

  always_ff @(posedge clk_i) begin
    if (c_en[1]) begin
      c2_comp_q   <= c1_comp_q;
      c2_fault_q  <= c1_fault_q;
      c2_flight_q <= c1_flight_q;
      c2_fneg_q   <= c1_k_q[47] == c1_dneg_q;
      c2_k_q      <= c1_k_q;
      c2_plo_q    <= 57'(c1_kmag_q[23:0]) * 57'(c1_dmag_q);
      c2_phi_q    <= 57'(c1_kmag_q[47:24]) * 57'(c1_dmag_q);
    end
  end

  // Stage C3: product sum, scaling back to FRAC_BITS, saturation.
  logic [MW-1:0] f_prod, f_shift;
  logic [QW-1:0] f_mag;

  assign f_prod  = MW'(c2_plo_q) + (MW'(c2_phi_q) << 24);
  assign f_shift = f_prod >> FRAC_BITS;
  assign f_mag   = hlvsf_pkg::sat_mag(f_shift, c2_fneg_q);

  logic               o_comp_q, o_fault_q;
  logic signed [47:0] o_k_q, o_f_q;

  always_ff @(posedge clk_i) begin
    if (c_en[2]) begin
      o_comp_q  <= c2_comp_q;
      o_fault_q <= c2_fault_q;
      o_k_q     <= c2_k_q;
      o_f_q     <= c2_flight_q ? '0 : (c2_fneg_q ? $signed(-f_mag) : $signed(f_mag));
    end
  end

  assign out_valid_o    = c_v_q[2];
  assign stiffness_o    = o_k_q;
  assign leg_force_o    = o_f_q;
  assign compressing_o  = o_comp_q;
  assign divide_fault_o = o_fault_q;

  // A divide fault only arises on the compression branch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> compressing_o)
    else $error("divide fault outside compression");

  // A divide fault forces the stiffness to zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_fault_o |-> stiffness_o == '0)
    else $error("stiffness not zero on divide fault");

  // No stiffness means no force.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stiffness_o == '0 |-> leg_force_o == '0)
    else $error("force without stiffness");

endmodule
